// File: hdl/sound_chip_write_router_top_macros.svh
// Shared assertion macros
`ifndef SOUND_CHIP_WRITE_ROUTER_TOP_MACROS_SVH
`define SOUND_CHIP_WRITE_ROUTER_TOP_MACROS_SVH

// same-cycle implication
`define SCWR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCWR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/scwr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scwr_pkg;

    localparam int NUM_CHANNELS = 12;
    localparam int CHAN_W       = 4;
    localparam int CHIP_W       = 4;
    localparam int VOICE_W      = 3;
    localparam int CFG_DATA_W   = 48;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef enum logic [1:0] {
        CFG_MUTE_MASK = 2'd0,
        CFG_CHIP_MAP  = 2'd1,
        CFG_VOICE_MAP = 2'd2
    } cfg_index_t;

    localparam logic [11:0] MUTE_MASK_RESET = 12'h000;
    localparam logic [47:0] CHIP_MAP_RESET  = 48'h0;
    localparam logic [35:0] VOICE_MAP_RESET = 36'h088163440;

    localparam logic [7:0] CMD_PSG       = 8'h00;
    localparam logic [7:0] CMD_MUTED     = 8'hFF;
    localparam logic [7:0] ADDR_KEY_ON   = 8'h28;
    localparam logic [7:0] ADDR_DAC_LO   = 8'h2A;
    localparam logic [7:0] ADDR_DAC_HI   = 8'h2B;
    localparam logic [7:0] ADDR_CH3_LO   = 8'hA8;
    localparam logic [7:0] ADDR_CH3_HI   = 8'hAE;
    localparam logic [7:0] ADDR_TIMER_LO = 8'h24;
    localparam logic [7:0] ADDR_TIMER_HI = 8'h27;
    localparam logic [7:0] ADDR_GLOBAL_HI = 8'h2F;
    localparam logic [7:0] ADDR_UPPER_LO = 8'hB8;
    localparam logic [7:0] LATCH_KEEP_MASK = 8'h9F;
    localparam logic [7:0] KEY_ON_KEEP_MASK = 8'hF8;

    localparam chan_t CHAN_GLOBAL = 4'd0;
    localparam chan_t CHAN_FM3    = 4'd3;
    localparam chan_t CHAN_FM6    = 4'd7;
    localparam chan_t CHAN_PSG0   = 4'd8;
    localparam chan_t CHAN_NOISE  = 4'd11;

    // raise FM voices 3..7 to 4..8
    function automatic logic [3:0] fm_voice(input logic [VOICE_W-1:0] v);
        logic [3:0] r;
        r = {1'b0, v};
        if (v >= 3'd3) begin
            r = r + 4'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/sound_chip_write_router_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_cmd_byte, s_reg_addr, s_write_data
// m_        out        m_valid/m_ready    m_cmd_out, m_addr_out, m_data_out, m_muted
// cfg_      in         cfg_wr_en          cfg_index, cfg_wr_data
//
// One request per cycle unless m_ready stalls; input register, then result register.
// The routing decode sits between the two registers and reads the remembered
// square/noise channel, which a latch updates as it moves to the result register.
// The input register fills while a result stalls, so one request waits behind it.
// Synchronous active-low reset empties both stages and restores the maps.

`include "sound_chip_write_router_top_macros.svh"

module sound_chip_write_router_top
    import scwr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_cmd_byte,
    input  wire logic [7:0]  s_reg_addr,
    input  wire logic [7:0]  s_write_data,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_cmd_out,
    output logic [7:0]       m_addr_out,
    output logic [7:0]       m_data_out,
    output logic             m_muted,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic        in_valid_reg;
    logic [7:0]  in_cmd_reg;
    logic [7:0]  in_addr_reg;
    logic [7:0]  in_data_reg;

    logic        out_valid_reg;
    logic [7:0]  out_cmd_reg;
    logic [7:0]  out_addr_reg;
    logic [7:0]  out_data_reg;
    logic        out_muted_reg;

    logic [11:0] mute_mask_reg;
    logic [47:0] chip_map_reg;
    logic [35:0] voice_map_reg;
    logic [1:0]  last_psg_reg;
    logic [1:0]  last_psg_next;

    logic [7:0]  cmd_next;
    logic [7:0]  addr_next;
    logic [7:0]  data_next;
    logic        muted_next;

    logic        advance;
    logic        is_latch;
    chan_t       ch;
    logic [VOICE_W-1:0] voice;
    logic [CHIP_W-1:0]  chip;
    logic [3:0]  voice_fm;
    logic [7:0]  cmd_work;
    logic [7:0]  addr_work;
    logic [7:0]  data_work;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign is_latch = (in_cmd_reg == CMD_PSG) && in_data_reg[7];

    always_comb begin
        ch = CHAN_GLOBAL;
        if (in_cmd_reg == CMD_PSG) begin
            if (in_data_reg[7]) begin
                ch = CHAN_PSG0 + {2'b00, in_data_reg[6:5]};
            end else begin
                ch = CHAN_PSG0 + {2'b00, last_psg_reg};
            end
        end else if (in_addr_reg == ADDR_KEY_ON) begin
            if (in_data_reg[2:0] < 3'd3) begin
                ch = {1'b0, in_data_reg[2:0]} + 4'd1;
            end else begin
                ch = {1'b0, in_data_reg[2:0]};
            end
        end else if (in_addr_reg == ADDR_DAC_LO || in_addr_reg == ADDR_DAC_HI) begin
            ch = CHAN_FM6;
        end else if ((in_addr_reg >= ADDR_CH3_LO && in_addr_reg <= ADDR_CH3_HI)
                  || (in_addr_reg >= ADDR_TIMER_LO && in_addr_reg <= ADDR_TIMER_HI)) begin
            ch = CHAN_FM3;
        end else if (in_addr_reg <= ADDR_GLOBAL_HI || in_addr_reg >= ADDR_UPPER_LO) begin
            ch = CHAN_GLOBAL;
        end else begin
            ch = {2'b00, in_addr_reg[1:0]} + (in_cmd_reg[0] ? 4'd4 : 4'd1);
        end
    end

    assign voice    = voice_map_reg[VOICE_W * int'(ch) +: VOICE_W];
    assign chip     = chip_map_reg[CHIP_W * int'(ch) +: CHIP_W];
    assign voice_fm = fm_voice(voice);

    always_comb begin
        cmd_work  = in_cmd_reg;
        addr_work = in_addr_reg;
        data_work = in_data_reg;
        if (in_cmd_reg == CMD_PSG) begin
            if (in_data_reg[7] && ch != CHAN_NOISE) begin
                data_work = (in_data_reg & LATCH_KEEP_MASK) | {1'b1, voice[1:0], 5'b00000};
            end
        end else if (in_addr_reg == ADDR_KEY_ON) begin
            data_work = (in_data_reg & KEY_ON_KEEP_MASK) | {4'b0000, voice_fm};
        end else if (!(in_addr_reg == ADDR_DAC_LO || in_addr_reg == ADDR_DAC_HI)
                  && !(in_addr_reg >= ADDR_CH3_LO && in_addr_reg <= ADDR_CH3_HI)
                  && !(in_addr_reg >= ADDR_TIMER_LO && in_addr_reg <= ADDR_TIMER_HI)
                  && !(in_addr_reg <= ADDR_GLOBAL_HI || in_addr_reg >= ADDR_UPPER_LO)) begin
            addr_work = {in_addr_reg[7:2], voice_fm[1:0]};
            cmd_work  = {in_cmd_reg[7:1], voice_fm[2]};
        end

        muted_next = mute_mask_reg[ch];
        if (muted_next) begin
            cmd_next  = CMD_MUTED;
            addr_next = in_addr_reg;
            data_next = in_data_reg;
        end else begin
            cmd_next  = cmd_work | {chip, 4'b0000};
            addr_next = addr_work;
            data_next = data_work;
        end

        last_psg_next = last_psg_reg;
        if (in_valid_reg && advance && is_latch) begin
            last_psg_next = in_data_reg[6:5];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_psg_reg  <= 2'd0;
            mute_mask_reg <= MUTE_MASK_RESET;
            chip_map_reg  <= CHIP_MAP_RESET;
            voice_map_reg <= VOICE_MAP_RESET;
        end else begin
            last_psg_reg <= last_psg_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MUTE_MASK: mute_mask_reg <= cfg_wr_data[11:0];
                    CFG_CHIP_MAP:  chip_map_reg  <= cfg_wr_data[47:0];
                    CFG_VOICE_MAP: voice_map_reg <= cfg_wr_data[35:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg  <= s_cmd_byte;
            in_addr_reg <= s_reg_addr;
            in_data_reg <= s_write_data;
        end
        if (advance && in_valid_reg) begin
            out_cmd_reg   <= cmd_next;
            out_addr_reg  <= addr_next;
            out_data_reg  <= data_next;
            out_muted_reg <= muted_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_cmd_out  = out_cmd_reg;
    assign m_addr_out = out_addr_reg;
    assign m_data_out = out_data_reg;
    assign m_muted    = out_muted_reg;

    `SCWR_ASSERT_NOW(a_muted_cmd, aclk, aresetn, m_valid && m_muted, m_cmd_out == CMD_MUTED, "muted request without muted command")
    `SCWR_ASSERT_NEXT(a_psg_hold, aclk, aresetn, !(in_valid_reg && advance && is_latch), $stable(last_psg_reg), "remembered channel changed without a latch")
    `SCWR_ASSERT_NEXT(a_stage_move, aclk, aresetn, in_valid_reg && advance, m_valid, "request lost between stages")

endmodule

`default_nettype wire

// File: bench/sound_chip_write_router_checker.sv
`timescale 1ns / 1ps

module sound_chip_write_router_checker
    import scwr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [7:0]            s_cmd_byte,
    input  logic [7:0]            s_reg_addr,
    input  logic [7:0]            s_write_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [7:0]            m_cmd_out,
    input  logic [7:0]            m_addr_out,
    input  logic [7:0]            m_data_out,
    input  logic                  m_muted,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int                    error_count,
    output int                    pending,
    output int                    checked_count
);

    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] addr;
        logic [7:0] data;
        logic       muted;
    } routed_write_t;

    logic [11:0]   mute_mask;
    logic [47:0]   chip_map;
    logic [35:0]   voice_map;
    logic [1:0]    last_psg_chan;
    routed_write_t expected_writes [$];

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("ERROR at %0t: %s expected %02h got %02h", $realtime, what, want, got);
        error_count++;
    endtask

    // FM voices 3..7 move up to 4..8
    function automatic logic [3:0] shifted_voice(input chan_t ch);
        logic [2:0] v;
        v = voice_map[3*ch +: 3];
        if (v >= 3'd3) begin
            return {1'b0, v} + 4'd1;
        end
        return {1'b0, v};
    endfunction

    function automatic routed_write_t route_write(input logic [7:0] cmd,
                                                  input logic [7:0] addr,
                                                  input logic [7:0] data);
        routed_write_t r;
        chan_t         ch;
        logic [3:0]    v;
        r = '{cmd, addr, data, 1'b0};
        if (cmd == CMD_PSG) begin
            if (data[7]) begin
                last_psg_chan = data[6:5];
            end
            ch = CHAN_PSG0 + {2'b00, last_psg_chan};
            if (data[7] && ch != CHAN_NOISE) begin
                r.data[6:5] = voice_map[3*ch +: 2];
            end
        end else if (addr == ADDR_KEY_ON) begin
            ch = {1'b0, data[2:0]};
            if (ch < 4'd3) begin
                ch = ch + 4'd1;
            end
            v = shifted_voice(ch);
            r.data = (data & KEY_ON_KEEP_MASK) | {4'b0, v};
        end else if (addr == ADDR_DAC_LO || addr == ADDR_DAC_HI) begin
            ch = CHAN_FM6;
        end else if ((addr >= ADDR_CH3_LO && addr <= ADDR_CH3_HI) ||
                     (addr >= ADDR_TIMER_LO && addr <= ADDR_TIMER_HI)) begin
            ch = CHAN_FM3;
        end else if (addr <= ADDR_GLOBAL_HI || addr >= ADDR_UPPER_LO) begin
            ch = CHAN_GLOBAL;
        end else begin
            ch = {2'b00, addr[1:0]} + {3'b000, cmd[0]} * 4'd3 + 4'd1;
            v = shifted_voice(ch);
            r.addr[1:0] = v[1:0];
            r.cmd[0] = v[2];
        end
        // muted writes carry the muted command, address and data untouched
        if (mute_mask[ch]) begin
            r = '{CMD_MUTED, addr, data, 1'b1};
        end else begin
            r.cmd = r.cmd | {chip_map[4*ch +: 4], 4'b0};
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        routed_write_t want;
        if (!aresetn) begin
            mute_mask = MUTE_MASK_RESET;
            chip_map = CHIP_MAP_RESET;
            voice_map = VOICE_MAP_RESET;
            last_psg_chan = '0;
            expected_writes.delete();
            error_count = 0;
            checked_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch("unrequested result, cmd_out", 8'h00, m_cmd_out);
                end else begin
                    want = expected_writes.pop_front();
                    checked_count++;
                    if (m_cmd_out !== want.cmd) begin
                        report_mismatch("cmd_out", want.cmd, m_cmd_out);
                    end
                    if (m_addr_out !== want.addr) begin
                        report_mismatch("addr_out", want.addr, m_addr_out);
                    end
                    if (m_data_out !== want.data) begin
                        report_mismatch("data_out", want.data, m_data_out);
                    end
                    if (m_muted !== want.muted) begin
                        report_mismatch("muted", {7'b0, want.muted}, {7'b0, m_muted});
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MUTE_MASK: mute_mask = cfg_wr_data[11:0];
                    CFG_CHIP_MAP:  chip_map = cfg_wr_data[47:0];
                    CFG_VOICE_MAP: voice_map = cfg_wr_data[35:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_writes.push_back(route_write(s_cmd_byte, s_reg_addr, s_write_data));
            end
        end
        pending = expected_writes.size();
    end

endmodule

// File: bench/sound_chip_write_router_top_tb.sv
`timescale 1ns / 1ps

module sound_chip_write_router_top_tb;
    import scwr_pkg::*;

    localparam int          CYCLE_LIMIT   = 100000;
    localparam int          PHASE_WRITES  = 50;
    localparam logic [7:0]  ADDR_OPER_LO  = 8'h30;
    localparam logic [7:0]  ADDR_OPER_HI  = 8'hB7;
    localparam logic [11:0] MUTE_ALL      = 12'hFFF;
    localparam logic [47:0] CHIP_ALL_TOP  = 48'hFFFF_FFFF_FFFF;
    localparam logic [35:0] VOICE_ALL_TOP = 36'hF_FFFF_FFFF;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_cmd_byte = '0;
    logic [7:0]            s_reg_addr = '0;
    logic [7:0]            s_write_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_cmd_out;
    logic [7:0]            m_addr_out;
    logic [7:0]            m_data_out;
    logic                  m_muted;
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int error_count;
    int pending;
    int checked_count;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int sent_count = 0;
    int setting_count = 0;

    sound_chip_write_router_top dut (.*);

    sound_chip_write_router_checker route_check (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_write(input logic [7:0] c, input logic [7:0] a, input logic [7:0] d);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd_byte <= c;
        s_reg_addr <= a;
        s_write_data <= d;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        sent_count++;
    endtask

    // hold off until every routed write is back
    task automatic drain();
        s_valid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [11:0] mute, input logic [47:0] chip,
                                  input logic [35:0] voice);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MUTE_MASK;
        cfg_wr_data <= {36'b0, mute};
        @(posedge aclk);
        cfg_index <= CFG_CHIP_MAP;
        cfg_wr_data <= chip;
        @(posedge aclk);
        cfg_index <= CFG_VOICE_MAP;
        cfg_wr_data <= {12'b0, voice};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        setting_count++;
    endtask

    task automatic send_random_write();
        logic [7:0] c;
        logic [7:0] a;
        logic [7:0] d;
        c = ($urandom_range(3) != 0) ? 8'($urandom_range(1, 2)) : 8'($urandom_range(1, 255));
        a = 8'($urandom);
        d = 8'($urandom);
        if ($urandom_range(99) < 30) begin
            c = CMD_PSG;
        end else begin
            case ($urandom_range(5))
                0: a = ADDR_KEY_ON;
                1: a = $urandom_range(1) ? ADDR_DAC_LO : ADDR_DAC_HI;
                2: a = $urandom_range(1) ? 8'($urandom_range(ADDR_CH3_LO, ADDR_CH3_HI))
                                         : 8'($urandom_range(ADDR_TIMER_LO, ADDR_TIMER_HI));
                3, 4: a = 8'($urandom_range(ADDR_OPER_LO, ADDR_OPER_HI));
                default: ;
            endcase
        end
        send_write(c, a, d);
    endtask

    initial begin
        logic [11:0] mute;
        logic [47:0] chip;
        logic [35:0] voice;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset maps: latches, key-on, every address class
        send_write(CMD_PSG, 8'h00, 8'h80);
        send_write(CMD_PSG, 8'h00, 8'h00);
        send_write(CMD_PSG, 8'h55, 8'hA5);
        send_write(CMD_PSG, 8'hFF, 8'h7F);
        send_write(CMD_PSG, 8'h00, 8'hDF);
        send_write(CMD_PSG, 8'h00, 8'hFF);
        send_write(CMD_PSG, 8'h00, 8'h01);
        send_write(8'h01, ADDR_KEY_ON, 8'h00);
        send_write(8'h01, ADDR_KEY_ON, 8'hF1);
        send_write(8'h02, ADDR_KEY_ON, 8'hF4);
        send_write(8'h01, ADDR_KEY_ON, 8'hFF);
        send_write(8'h01, ADDR_DAC_LO, 8'h80);
        send_write(8'h01, ADDR_DAC_HI, 8'hFF);
        send_write(8'h01, ADDR_CH3_LO, 8'h12);
        send_write(8'h01, ADDR_CH3_HI, 8'h34);
        send_write(8'h01, ADDR_TIMER_LO, 8'h56);
        send_write(8'h01, ADDR_GLOBAL_HI, 8'hFF);
        send_write(8'h01, ADDR_UPPER_LO, 8'h01);
        send_write(8'hFF, 8'hFF, 8'hFF);
        send_write(8'h01, ADDR_OPER_LO, 8'hAA);
        send_write(8'h02, 8'h33, 8'h55);
        send_write(8'hF1, ADDR_OPER_HI, 8'h0F);
        drain();

        // muted latch still moves the remembered channel; top voices everywhere
        apply_settings(12'h300, CHIP_ALL_TOP, VOICE_ALL_TOP);
        send_write(CMD_PSG, 8'h00, 8'hA0);
        send_write(CMD_PSG, 8'h00, 8'h05);
        send_write(CMD_PSG, 8'h00, 8'hC0);
        send_write(CMD_PSG, 8'h00, 8'h05);
        send_write(8'h01, ADDR_KEY_ON, 8'h07);
        send_write(8'h01, 8'h31, 8'h00);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            mute = 12'($urandom);
            chip = 48'({$urandom, $urandom});
            voice = 36'({$urandom, $urandom});
            case (phase)
                0: mute = MUTE_MASK_RESET;
                1: begin
                    chip = CHIP_ALL_TOP;
                    voice = VOICE_ALL_TOP;
                end
                3: mute = MUTE_ALL;
                7: begin
                    mute = '0;
                    chip = '0;
                    voice = '0;
                end
                default: ;
            endcase
            apply_settings(mute, chip, voice);
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 47;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 47;
                end
                default: begin
                    send_idle_pct = 37;
                    recv_stall_pct = 37;
                end
            endcase
            for (int k = 0; k < PHASE_WRITES; k++) begin
                if (phase == 2 && k == PHASE_WRITES / 2) begin
                    drain();
                end
                send_random_write();
            end
            drain();
        end

        $display("Sent %0d requests under %0d register settings and four handshake phases",
                 sent_count, setting_count);
        $display("Compared %0d routed writes, %0d mismatches", checked_count, error_count);
        if (error_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
